// ----- hdl/sliding_window_median_core_defines.svh -----
// Assertion macros used by the checker file of the median filter.
`ifndef SLIDING_WINDOW_MEDIAN_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_DEFINES_SVH

// Same-cycle implication, silent while reset is high.
`define SWM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, silent while reset is high.
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/swm_pkg.sv -----
// Shared types, constants and control structs of the sliding window median filter.
package swm_pkg;

   localparam int WINDOW_LEN  = 21;
   localparam int VALUE_BITS  = 27;
   localparam int MID_POS     = WINDOW_LEN / 2;
   localparam int IDX_BITS    = $clog2(WINDOW_LEN);
   localparam int COUNT_BITS  = $clog2(WINDOW_LEN + 1);
   localparam int TDATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
   localparam int TUSER_BITS  = 8;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [VALUE_BITS-1:0] MIN_RESET = VALUE_BITS'(100);
   localparam logic [VALUE_BITS-1:0] MAX_RESET = VALUE_BITS'(100000000);

   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_VALUE = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_VALUE = 1'b1;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_REMOVE,
      ST_INSERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic classify;
      logic remove;
      logic insert;
      logic emit;
   } swm_cmd_type;

   typedef struct packed {
      logic reject;
      logic full;
      logic rsp_busy;
   } swm_status_type;

endpackage

// ----- hdl/swm_ctrl.sv -----
// Sequencer of the median filter: walks one word through classify, remove and insert as needed, and emit.
module swm_ctrl import swm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  swm_status_type status,
   output swm_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (status.reject) begin
               state_in = ST_EMIT;
            end else if (status.full) begin
               state_in = ST_REMOVE;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_REMOVE: state_in = ST_INSERT;
         ST_INSERT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_CLASSIFY: cmd.classify = 1'b1;
         ST_REMOVE:   cmd.remove   = 1'b1;
         ST_INSERT:   cmd.insert   = 1'b1;
         ST_EMIT:     cmd.emit     = !status.rsp_busy;
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ----- hdl/swm_datapath.sv -----
// Window storage, sorted copy, range check, config registers and result register.
module swm_datapath import swm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  swm_cmd_type             cmd,
   output swm_status_type          status,
   input  logic [TDATA_BITS-1:0]   req_tdata,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [VALUE_BITS-1:0]   csr_data,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [TDATA_BITS-1:0]   rsp_tdata,
   output logic [TUSER_BITS-1:0]   rsp_tuser
);

   value_type min_ff, max_ff;
   value_type sample_ff;
   value_type old_ff;
   value_type ring_ff [WINDOW_LEN];
   value_type srt_ff  [WINDOW_LEN];
   value_type rem_in  [WINDOW_LEN];
   value_type ins_in  [WINDOW_LEN];
   count_type fill_ff;
   idx_type   oldest_ff;
   logic      rej_ff, win_full_ff;
   logic      rsp_valid_ff;
   value_type rsp_median_ff;
   logic      rsp_full_ff, rsp_rej_ff;

   logic                  reject;
   logic                  full;
   count_type             ins_n;
   logic [WINDOW_LEN-1:0] gt;
   logic [WINDOW_LEN-1:0] gt_prev;
   logic [WINDOW_LEN-1:0] eq;
   logic [WINDOW_LEN-1:0] after;

   assign csr_ready = 1'b1;
   assign reject    = (sample_ff < min_ff) || (sample_ff > max_ff);
   assign full      = (fill_ff == COUNT_BITS'(WINDOW_LEN));

   assign status.reject   = reject;
   assign status.full     = full;
   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;

   // Drop the first entry equal to the leaving value, close the gap upward.
   always_comb begin
      for (int j = 0; j < WINDOW_LEN; j++) begin
         eq[j] = (srt_ff[j] == old_ff);
      end
      after[0] = eq[0];
      for (int j = 1; j < WINDOW_LEN; j++) begin
         after[j] = after[j-1] | eq[j];
      end
      for (int j = 0; j < WINDOW_LEN - 1; j++) begin
         rem_in[j] = after[j] ? srt_ff[j+1] : srt_ff[j];
      end
      rem_in[WINDOW_LEN-1] = srt_ff[WINDOW_LEN-1];
   end

   // Open a slot after the last held entry not above the new value.
   always_comb begin
      ins_n = win_full_ff ? COUNT_BITS'(WINDOW_LEN - 1) : fill_ff;
      for (int j = 0; j < WINDOW_LEN; j++) begin
         gt[j] = (COUNT_BITS'(j) < ins_n) && (srt_ff[j] > sample_ff);
      end
      gt_prev[0] = 1'b0;
      for (int j = 1; j < WINDOW_LEN; j++) begin
         gt_prev[j] = gt[j-1];
      end
      if ((ins_n != '0) && !gt[0]) begin
         ins_in[0] = srt_ff[0];
      end else begin
         ins_in[0] = sample_ff;
      end
      for (int j = 1; j < WINDOW_LEN; j++) begin
         if ((COUNT_BITS'(j) < ins_n) && !gt[j]) begin
            ins_in[j] = srt_ff[j];
         end else if (gt_prev[j]) begin
            ins_in[j] = srt_ff[j-1];
         end else begin
            ins_in[j] = sample_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_RESET;
         max_ff <= MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_VALUE: min_ff <= csr_data;
            CSR_MAX_VALUE: max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         oldest_ff <= '0;
      end else begin
         if (cmd.insert && !win_full_ff) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.remove) begin
            oldest_ff <= (oldest_ff == idx_type'(WINDOW_LEN - 1)) ? '0 : oldest_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_tdata[VALUE_BITS-1:0];
      end
      if (cmd.classify) begin
         rej_ff      <= reject;
         win_full_ff <= !reject && full;
         old_ff      <= ring_ff[oldest_ff];
      end
      if (cmd.remove) begin
         ring_ff[oldest_ff] <= sample_ff;
         for (int j = 0; j < WINDOW_LEN; j++) begin
            srt_ff[j] <= rem_in[j];
         end
      end
      if (cmd.insert) begin
         if (!win_full_ff) begin
            ring_ff[fill_ff[IDX_BITS-1:0]] <= sample_ff;
         end
         for (int j = 0; j < WINDOW_LEN; j++) begin
            srt_ff[j] <= ins_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_rej_ff  <= rej_ff;
         rsp_full_ff <= win_full_ff;
         if (rej_ff) begin
            rsp_median_ff <= '0;
         end else if (win_full_ff) begin
            rsp_median_ff <= srt_ff[MID_POS];
         end else begin
            rsp_median_ff <= sample_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'(rsp_median_ff);
   assign rsp_tuser  = TUSER_BITS'({rsp_rej_ff, rsp_full_ff});

endmodule

// ----- hdl/sliding_window_median_core.sv -----
// Top level of the sliding window median filter: sequencer plus datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------
//  req     | in        | req_tvalid/req_tready | tdata[26:0] sample_value
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata[26:0] median_value,
//          |           |                       | tuser[0] window_full, tuser[1] rejected
//  csr     | in        | csr_valid/csr_ready   | csr_index (0 min, 1 max), csr_data
//
//  A word goes from acceptance to the result register through classify and emit when
//  rejected, through classify, insert and emit while the window fills, and through
//  classify, remove, insert and emit once it is full, one step per cycle save an emit
//  held by a stalled result; the sequencer then returns to idle to take the next word.
//  Synchronous active-high reset clears the sequencer, fill count, oldest pointer,
//  result valid and restores min 100 / max 100000000; window contents need no reset.
//  A stalled result holds in the output register; the next word may be taken
//  meanwhile, and its emit step waits until the register is free.
//  Configuration is always ready and is meant to be written only while idle.
module sliding_window_median_core import swm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // sample_value [26:0], zero pad above
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [TDATA_BITS-1:0]   req_tdata,
   // median_value [26:0], zero pad above
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [TDATA_BITS-1:0]   rsp_tdata,
   // window_full [0], rejected [1], zero pad above
   output logic [TUSER_BITS-1:0]   rsp_tuser,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [VALUE_BITS-1:0]   csr_data
);

   swm_cmd_type    cmd;
   swm_status_type status;

   // Sequencer: one step of the update per cycle, but emit waits while a stalled result holds the register.
   swm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: arrival ring, sorted copy, range check and result word.
   swm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- hdl/swm_checker.sv -----
// Port-level checks of the median filter, bound to the top level.
`include "sliding_window_median_core_defines.svh"

module swm_checker import swm_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [TDATA_BITS-1:0] rsp_tdata,
   input logic [TUSER_BITS-1:0] rsp_tuser
);

   `SWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp word dropped while stalled")

   `SWM_ASSERT_NOW(a_reject_clean, clock, reset, rsp_tvalid && rsp_tuser[1], (rsp_tdata == '0) && !rsp_tuser[0], "rejected word carries a median or full flag")

   `SWM_ASSERT_NEXT(a_busy_after_take, clock, reset, req_tvalid && req_tready, !req_tready, "new word taken while one is in work")

   `SWM_ASSERT_NOW(a_no_rsp_after_reset, clock, reset, $past(reset), !rsp_tvalid, "result valid straight after reset")

endmodule

bind sliding_window_median_core swm_checker u_swm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
